FILE: rtl/bbsf_pkg.sv
`timescale 1ns / 1ps

package bbsf_pkg;

   // ring store geometry
   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   // byte counts, offsets and capacity share the field width
   localparam int CNT_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 32;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_POP   = 2'd1,
      KIND_END   = 2'd2,
      KIND_PEEK  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  amount;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [BYTE_W-1:0]  peek_byte;
      logic               peek_valid;
      logic [CNT_W-1:0]   buffered;
      logic [CNT_W-1:0]   space_left;
      logic [TOTAL_W-1:0] total_written;
      logic [TOTAL_W-1:0] total_read;
      logic               ended;
      logic               at_eof;
   } rsp_type;

   // base + offset around the ring; correct only for offsets up to DEPTH
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/bbsf_ram.sv
`timescale 1ns / 1ps

module bbsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bounded_byte_stream_fifo_unit.sv
`timescale 1ns / 1ps
// bounded byte fifo, one operation per transfer, one result per operation
// an accepted operation is held in the input register; the state registers and
//    the result register with its strobe are then written together
// throughput: 1 item per cycle, busy is never raised; the receiver cannot stall
// reset: synchronous active high, clears pointers, counts, totals, flags and
//    sets capacity to 1024; the byte store is not cleared

module bounded_byte_stream_fifo_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bbsf_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output bbsf_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [bbsf_pkg::CNT_W-1:0]     csr_wr_data
);
   import bbsf_pkg::*;

   // input register
   req_type            req_ff;
   logic               req_valid_ff;

   // fifo state
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [TOTAL_W-1:0] wtotal_ff, wtotal_in;
   logic [TOTAL_W-1:0] rtotal_ff, rtotal_in;
   logic               done_ff, done_in;
   logic               eos_ff, eos_in;
   logic [CNT_W-1:0]   capacity_ff;

   // result register
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff;

   // ring store access
   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;

   logic [CNT_W-1:0]   eff_cap;
   logic [CNT_W-1:0]   pop_n;
   logic [CNT_W-1:0]   space;
   logic               wr_ok;
   logic               peek_ok;

   // every cycle can take a transfer
   assign busy = 1'b0;

   // capacity above the store depth is clipped to the depth
   assign eff_cap = (capacity_ff > DEPTH_CNT) ? DEPTH_CNT : capacity_ff;

   // pops saturate at the bytes present
   assign pop_n   = (req_ff.amount < fill_ff) ? req_ff.amount : fill_ff;
   assign wr_ok   = (fill_ff < eff_cap);
   assign peek_ok = (req_ff.amount < fill_ff);

   // tail slot for writes, head + offset for peeks
   assign ram_waddr = ring_add(head_ff, fill_ff);
   assign ram_raddr = ring_add(head_ff, req_ff.amount);

   // state update for the registered operation
   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      wtotal_in = wtotal_ff;
      rtotal_in = rtotal_ff;
      done_in   = done_ff;
      eos_in    = eos_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      if (req_valid_ff) begin
         case (req_ff.kind)
            KIND_WRITE: begin
               if (wr_ok) begin
                  ram_we    = 1'b1;
                  fill_in   = fill_ff + CNT_W'(1);
                  wtotal_in = wtotal_ff + TOTAL_W'(1);
               end
            end
            KIND_POP: begin
               head_in   = ring_add(head_ff, pop_n);
               fill_in   = fill_ff - pop_n;
               rtotal_in = rtotal_ff + TOTAL_W'(pop_n);
               // even a zero-length pop can close the stream
               if (done_ff && (fill_in == '0)) begin
                  eos_in = 1'b1;
               end
            end
            KIND_END: begin
               done_in = 1'b1;
               if (fill_ff == '0) begin
                  eos_in = 1'b1;
               end
            end
            KIND_PEEK: begin
               ram_re = peek_ok;
            end
            default: begin
            end
         endcase
      end
   end

   // space floors at zero when capacity was lowered under the fill
   assign space = (fill_in < eff_cap) ? (eff_cap - fill_in) : '0;

   // result fields; the peeked byte joins from the ram read register
   always_comb begin
      rsp_in               = '0;
      rsp_in.accepted      = req_valid_ff && (req_ff.kind == KIND_WRITE) && wr_ok;
      rsp_in.peek_valid    = req_valid_ff && (req_ff.kind == KIND_PEEK) && peek_ok;
      rsp_in.buffered      = fill_in;
      rsp_in.space_left    = space;
      rsp_in.total_written = wtotal_in;
      rsp_in.total_read    = rtotal_in;
      rsp_in.ended         = done_in;
      rsp_in.at_eof        = eos_in;
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.peek_byte = rsp_ff.peek_valid ? ram_rdata : '0;
   end

   assign rsp_strobe = rsp_strobe_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         head_ff       <= '0;
         fill_ff       <= '0;
         wtotal_ff     <= '0;
         rtotal_ff     <= '0;
         done_ff       <= 1'b0;
         eos_ff        <= 1'b0;
         capacity_ff   <= CAP_RESET;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         wtotal_ff     <= wtotal_in;
         rtotal_ff     <= rtotal_in;
         done_ff       <= done_in;
         eos_ff        <= eos_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   bbsf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ff.data_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // fill never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("fill count beyond store depth");

   // end of stream is sticky
   a_eos_sticky: assert property (@(posedge clock) disable iff (reset)
      eos_ff |=> eos_ff)
      else $error("end of stream flag dropped");

   // every registered operation gives exactly one result in the following cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("operation without result");

   // a reported end of stream implies that input has ended
   a_eof_ended: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.at_eof) |-> rsp_data.ended)
      else $error("end of stream without end of input");

endmodule
